// File: design/sha1md_pkg.sv
`default_nettype none
package sha1md_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 80;

	localparam chain_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

	typedef struct packed {
		logic  push;
		word_t word;
		logic  start;
		logic  reinit;
	} core_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage
`default_nettype wire

// File: design/sha1md_in_if.sv
`default_nettype none
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source(output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink(input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface
`default_nettype wire

// File: design/sha1md_out_if.sv
`default_nettype none
interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: design/sha1md_core.sv
`default_nettype none
module sha1md_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sha1md_pkg::core_cmd_t  cmd,
	output sha1md_pkg::core_stat_t      stat,
	output sha1md_pkg::chain_t          chain
);
	import sha1md_pkg::*;

	chain_t                  chain_q;
	logic [15:0][31:0]       w_q;
	word_t                   a_q, b_q, c_q, d_q, e_q;
	logic [6:0]              rnd_q;
	logic                    busy_q;
	logic                    done_q;

	word_t f, k, t, w_next, w_mix;
	logic  final_rnd;

	assign final_rnd = (rnd_q == 7'(ROUNDS));

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_R0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_R1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_R2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_R3;
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];

	// schedule window holds w[r..r+15], oldest at index 0
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			w_q <= {cmd.word, w_q[15:1]};
		end else if (busy_q && !final_rnd) begin
			w_q <= {w_next, w_q[15:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q && !final_rnd) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_CHAIN;
			rnd_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.reinit) begin
				chain_q <= INIT_CHAIN;
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (final_rnd) begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign chain = chain_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q && rnd_q == 7'd0)
		else $error("compression did not start");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rnd_q <= 7'(ROUNDS))
		else $error("round counter overran");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(final_rnd))
		else $error("done without final round");
endmodule
`default_nettype wire

// File: design/sha1_message_digest.sv
`default_nettype none
// input: message bytes are taken while idle; each 64th byte starts a compression of the block
// (80 rounds through one shared round unit, then the chaining add and the done handoff)
// end of message: 9 to 72 padding bytes, one or two compressions, then 5 digest words
// input is stalled while a block is compressed, since the single round unit is busy
// reset: chaining words to the initial hash values, length zero; block buffer not cleared
module sha1_message_digest (
	input wire logic    clk,
	input wire logic    arst_n,
	sha1md_in_if.sink   msg,
	sha1md_out_if.source digest
);
	import sha1md_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_OUT} state_t;

	state_t      state_q;
	logic [5:0]  pos_q;
	logic [63:0] bit_len_q;
	logic [23:0] acc_q;
	logic        padding_q;
	logic        first_q;
	logic        need_len_q;
	logic [2:0]  idx_q;

	core_cmd_t   cmd;
	core_stat_t  stat;
	chain_t      chain;

	logic        byte_go;
	logic [7:0]  cur_byte;
	logic [7:0]  len_byte;
	logic        out_last;

	assign len_byte = bit_len_q[{~pos_q[2:0], 3'b000} +: 8];

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				byte_go = msg.valid && msg.byte_valid;
				cur_byte = msg.data_byte;
			end
			ST_PAD: begin
				byte_go = 1'b1;
				priority if (first_q) begin
					cur_byte = PAD_BYTE;
				end else if (need_len_q && pos_q >= LEN_POS) begin
					cur_byte = len_byte;
				end else begin
					cur_byte = '0;
				end
			end
			default: begin
				byte_go = 1'b0;
				cur_byte = msg.data_byte;
			end
		endcase
	end

	assign out_last = (state_q == ST_OUT) && digest.ready && (idx_q == LAST_IDX);

	assign cmd.push = byte_go && (pos_q[1:0] == 2'b11);
	assign cmd.word = {acc_q, cur_byte};
	assign cmd.start = byte_go && (pos_q == LAST_POS);
	assign cmd.reinit = out_last;

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			bit_len_q <= '0;
			acc_q <= '0;
			padding_q <= 1'b0;
			first_q <= 1'b0;
			need_len_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (byte_go) begin
				acc_q <= {acc_q[15:0], cur_byte};
				pos_q <= pos_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg.valid) begin
						if (msg.byte_valid) begin
							bit_len_q <= bit_len_q + 64'd8;
						end
						if (msg.end_of_message) begin
							padding_q <= 1'b1;
							first_q <= 1'b1;
						end
						priority if (msg.byte_valid && pos_q == LAST_POS) begin
							state_q <= ST_COMP;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (first_q) begin
						// length fits in this block only if the marker lands before it
						need_len_q <= (pos_q < LEN_POS);
					end
					if (pos_q == LAST_POS) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (stat.done) begin
						priority if (!padding_q) begin
							state_q <= ST_IDLE;
						end else if (first_q) begin
							state_q <= ST_PAD;
						end else if (need_len_q) begin
							state_q <= ST_OUT;
							idx_q <= '0;
						end else begin
							need_len_q <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (digest.ready) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
							pos_q <= '0;
							bit_len_q <= '0;
							padding_q <= 1'b0;
							need_len_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign msg.ready = (state_q == ST_IDLE);
	assign digest.valid = (state_q == ST_OUT);
	assign digest.digest_word = chain[idx_q];
	assign digest.word_index = idx_q;
	assign digest.last_word = (idx_q == LAST_IDX);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid && !stat.busy)
		else $error("input taken while busy");
	a_start_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> cmd.push && !stat.busy)
		else $error("compression started on a partial block");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> idx_q <= LAST_IDX)
		else $error("digest index out of range");
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		out_last |=> pos_q == 6'd0 && bit_len_q == 64'd0 && !padding_q)
		else $error("state not cleared after digest");
endmodule
`default_nettype wire
